FILE: hw/rtl/pcpm_pkg.sv
package pcpm_pkg;

	// Width of the shared divider's dividend and quotient.
	localparam int DIVW = 40;
	// Width of every divisor (lit count and segment weight).
	localparam int DSW = 16;

	localparam logic [1:0] OP_LOAD_COLOUR = 2'd0;
	localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
	localparam logic [1:0] OP_FRAME       = 2'd2;
	localparam logic [1:0] OP_POINT       = 2'd3;

	localparam logic CFG_COLOUR_COUNT = 1'b0;
	localparam logic CFG_BLEND_ENABLE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_QDIV,
		ST_QWAIT,
		ST_SUMR,
		ST_SUMA,
		ST_TGT,
		ST_SRCHR,
		ST_SRCHA,
		ST_FDIV,
		ST_FWAIT,
		ST_RDC,
		ST_RDN,
		ST_RDX,
		ST_MIX,
		ST_DONE
	} pcpm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pcpm_div_stat_t;

endpackage

FILE: hw/rtl/pcpm_div.sv
module pcpm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcpm_pkg::DIVW-1:0]    dividend,
	input  logic [pcpm_pkg::DSW-1:0]     divisor,
	output logic [pcpm_pkg::DIVW-1:0]    quotient,
	output pcpm_pkg::pcpm_div_stat_t     stat
);
	import pcpm_pkg::*;

	localparam int CNTW = $clog2(DIVW + 1);

	logic [DSW-1:0]  rem_q;
	logic [DSW-1:0]  dsr_q;
	logic [DIVW-1:0] quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DSW:0]    trial;
	logic            qbit;
	logic [DSW-1:0]  rem_next;

	// One restoring step per cycle: the remainder takes the next dividend bit.
	always_comb begin
		trial = {rem_q, quo_q[DIVW-1]} - {1'b0, dsr_q};
		qbit = !trial[DSW];
		rem_next = qbit ? trial[DSW-1:0] : {rem_q[DSW-2:0], quo_q[DIVW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(DIVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVW-2:0], qbit};
		end
	end

	assign quotient = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/proportional_colour_pattern_mapper.sv
// Load and frame words are taken in the idle state and leave it idle. A passed point goes
// from the idle state through the done state to the output register. A painted point waits
// on the shared 40-step restoring divider once, or twice when blending and a segment is hit,
// and steps through the segments for the weight sum and then for the segment search; output
// stalls hold it in the done state. Words are taken one at a time: after a point, the next
// word is taken the cycle after the result register is loaded.
// Reset (arst_n low, asynchronous) restores all colours to white, all weights to one,
// the frame to zero lit points with one repeat, and the registers to one colour, no blend.
module proportional_colour_pattern_mapper #(
	parameter int MAX_COLOURS  = 8,
	parameter int CHANNEL_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [2:0]         entry_index,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [15:0]        proportion,
	input  logic [15:0]        lit_count,
	input  logic [15:0]        phase,
	input  logic signed [15:0] repeats,
	input  logic               blanked,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic               out_blanked,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);
	import pcpm_pkg::*;

	// Table index width, segment count width and the width of a weight sum.
	localparam int IW  = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
	localparam int CW  = $clog2(MAX_COLOURS + 1);
	localparam int TW  = DSW + IW;
	localparam int TGW = TW + 16;
	// Full scale of one channel as the table stores it.
	localparam logic [7:0] CH_MASK = (CHANNEL_BITS >= 8) ? 8'hFF :
		8'((1 << CHANNEL_BITS) - 1);
	localparam logic [23:0] WHITE = {CH_MASK, CH_MASK, CH_MASK};
	localparam logic [15:0] W_ONE = 16'd256;

	pcpm_state_t state_q, state_d;

	// Configuration registers. The port never pushes back.
	logic [3:0] colour_count_q;
	logic       blend_q;

	// Frame state.
	logic [15:0] lit_q;
	logic [15:0] phase_q;
	logic [15:0] rep_q;
	logic [15:0] cnt_q;

	// Colour and weight tables. An entry never written reads as its reset value,
	// which the valid bits supply.
	logic [23:0]            cmem [MAX_COLOURS];
	logic [15:0]            wmem [MAX_COLOURS];
	logic [MAX_COLOURS-1:0] cvld_q;
	logic [MAX_COLOURS-1:0] wvld_q;
	logic [23:0]            crd_q;
	logic [15:0]            wrd_q;
	logic                   crd_vld_q;
	logic                   wrd_vld_q;
	logic [23:0]            cdata;
	logic [15:0]            wdata;
	logic [IW-1:0]          c_raddr;

	// Per-point working registers.
	logic [7:0]          res_r_q, res_g_q, res_b_q;
	logic [15:0]         res_x_q, res_y_q;
	logic                res_bl_q;
	logic                adv_q;
	logic                neg_q;
	logic [31:0]         prod_q;
	logic [15:0]         theta_q;
	logic [TW-1:0]       total_q;
	logic [TW-1:0]       pt_q;
	logic [TGW-1:0]      target_q;
	logic [CW-1:0]       k_q;
	logic [15:0]         wsel_q;
	logic [15:0]         f_q;
	logic [23:0]         cur_q, nxt_q;
	logic [1:0]          ch_q;

	// Output register.
	logic        out_valid_q;
	logic [15:0] out_x_q, out_y_q;
	logic [7:0]  out_r_q, out_g_q, out_b_q;
	logic        out_bl_q;

	// Shared divider.
	logic              div_start;
	logic [DIVW-1:0]   div_dividend;
	logic [DSW-1:0]    div_divisor;
	logic [DIVW-1:0]   div_quo;
	pcpm_div_stat_t    div_stat;

	logic            accept;
	logic            write_ok;
	logic [IW-1:0]   widx;
	logic [CW-1:0]   nc;
	logic            passing;
	logic [15:0]     rep_mag;
	logic [DIVW-1:0] mag;
	logic [CW-1:0]   k_inc;
	logic [CW-1:0]   nxt_k;
	logic [TW-1:0]   pt_w;
	logic            seg_hit;
	logic            last_k;
	logic [15:0]     f_sat;
	logic [15:0]     theta_d;
	logic            out_free;
	logic [7:0]      mix_c, mix_n;
	logic signed [8:0]  mix_d;
	logic signed [26:0] mix_sum;
	logic [7:0]      mix_res;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	assign write_ok = (32'(entry_index) < MAX_COLOURS);
	assign widx     = IW'(entry_index);
	assign nc = (32'(colour_count_q) > MAX_COLOURS) ? CW'(MAX_COLOURS) : CW'(colour_count_q);
	assign passing = blanked || (nc == '0) || (lit_q == '0);

	// The next colour wraps to the first at the last segment in use.
	assign k_inc = k_q + 1'b1;
	assign last_k = (k_inc == nc);
	assign nxt_k = last_k ? '0 : k_inc;

	assign cdata = crd_vld_q ? crd_q : WHITE;
	assign wdata = wrd_vld_q ? wrd_q : W_ONE;
	assign c_raddr = (state_q == ST_RDN) ? nxt_k[IW-1:0] : k_q[IW-1:0];

	// Negative repeats divide the magnitude rounding up, then subtract from the phase,
	// which gives the floor of the signed quotient.
	assign rep_mag = rep_q[15] ? (16'd0 - rep_q) : rep_q;
	assign mag = neg_q ? ({prod_q, 8'd0} + DIVW'(lit_q) - DIVW'(1)) : {prod_q, 8'd0};
	assign theta_d = neg_q ? (phase_q - div_quo[15:0]) : (div_quo[15:0] + phase_q);

	assign pt_w = pt_q + TW'(wdata);
	assign seg_hit = ({pt_w, 16'd0} > target_q);
	assign f_sat = (div_quo > DIVW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];

	always_comb begin
		div_start = 1'b0;
		div_dividend = mag;
		div_divisor = lit_q;
		if (state_q == ST_QDIV) begin
			div_start = 1'b1;
		end else if (state_q == ST_FDIV) begin
			div_start = 1'b1;
			div_dividend = DIVW'(target_q - {pt_q, 16'd0});
			div_divisor = wsel_q;
		end
	end

	// One channel per cycle: c + (n - c) * f / 65536, rounded to nearest.
	always_comb begin
		case (ch_q)
			2'd0: begin
				mix_c = cur_q[23:16];
				mix_n = nxt_q[23:16];
			end
			2'd1: begin
				mix_c = cur_q[15:8];
				mix_n = nxt_q[15:8];
			end
			default: begin
				mix_c = cur_q[7:0];
				mix_n = nxt_q[7:0];
			end
		endcase
		mix_d = $signed({1'b0, mix_n}) - $signed({1'b0, mix_c});
		mix_sum = $signed({3'b0, mix_c, 16'd0}) + (mix_d * $signed({1'b0, f_q}))
			+ 27'sd32768;
		mix_res = mix_sum[23:16] & CH_MASK;
	end

	pcpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_POINT) begin
					state_d = passing ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_QDIV;
			ST_QDIV:  state_d = ST_QWAIT;
			ST_QWAIT: begin
				if (div_stat.done) begin
					state_d = ST_SUMR;
				end
			end
			ST_SUMR:  state_d = ST_SUMA;
			ST_SUMA:  state_d = last_k ? ST_TGT : ST_SUMR;
			ST_TGT:   state_d = ST_SRCHR;
			ST_SRCHR: state_d = ST_SRCHA;
			ST_SRCHA: begin
				if (seg_hit) begin
					state_d = blend_q ? ST_FDIV : ST_RDC;
				end else if (last_k) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SRCHR;
				end
			end
			ST_FDIV:  state_d = ST_FWAIT;
			ST_FWAIT: begin
				if (div_stat.done) begin
					state_d = ST_RDC;
				end
			end
			ST_RDC:   state_d = ST_RDN;
			ST_RDN:   state_d = ST_RDX;
			ST_RDX:   state_d = blend_q ? ST_MIX : ST_DONE;
			ST_MIX: begin
				if (ch_q == 2'd2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, frame state, valid bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_count_q <= 4'd1;
			blend_q <= 1'b0;
			lit_q <= '0;
			phase_q <= '0;
			rep_q <= W_ONE;
			cnt_q <= '0;
			cvld_q <= '0;
			wvld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_COLOUR_COUNT) begin
					colour_count_q <= cfg_data;
				end else begin
					blend_q <= cfg_data[0];
				end
			end
			if (accept && opcode == OP_LOAD_COLOUR && write_ok) begin
				cvld_q[widx] <= 1'b1;
			end
			if (accept && opcode == OP_LOAD_WEIGHT && write_ok) begin
				wvld_q[widx] <= 1'b1;
			end
			if (accept && opcode == OP_FRAME) begin
				lit_q <= lit_count;
				phase_q <= phase;
				rep_q <= repeats;
				cnt_q <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				if (adv_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Table memories with registered reads.
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_LOAD_COLOUR && write_ok) begin
			cmem[widx] <= {red, green, blue};
		end
		if (accept && opcode == OP_LOAD_WEIGHT && write_ok) begin
			wmem[widx] <= (proportion == '0) ? 16'd1 : proportion;
		end
		crd_q <= cmem[c_raddr];
		crd_vld_q <= cvld_q[c_raddr];
		wrd_q <= wmem[k_q[IW-1:0]];
		wrd_vld_q <= wvld_q[k_q[IW-1:0]];
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_x_q <= pos_x;
				res_y_q <= pos_y;
				res_r_q <= red;
				res_g_q <= green;
				res_b_q <= blue;
				res_bl_q <= blanked;
				adv_q <= 1'b0;
				neg_q <= rep_q[15];
				k_q <= '0;
				total_q <= '0;
				pt_q <= '0;
				ch_q <= '0;
			end
			ST_MUL: prod_q <= 32'(cnt_q) * 32'(rep_mag);
			ST_QWAIT: begin
				if (div_stat.done) begin
					theta_q <= theta_d;
				end
			end
			ST_SUMA: begin
				total_q <= total_q + TW'(wdata);
				k_q <= k_inc;
			end
			ST_TGT: begin
				target_q <= TGW'(theta_q) * TGW'(total_q);
				k_q <= '0;
			end
			ST_SRCHA: begin
				if (seg_hit) begin
					wsel_q <= wdata;
				end else begin
					pt_q <= pt_w;
					k_q <= k_inc;
					if (last_k) begin
						res_r_q <= '0;
						res_g_q <= '0;
						res_b_q <= '0;
					end
				end
			end
			ST_FWAIT: begin
				if (div_stat.done) begin
					f_q <= f_sat;
				end
			end
			ST_RDN: cur_q <= cdata;
			ST_RDX: begin
				nxt_q <= cdata;
				adv_q <= 1'b1;
				res_r_q <= cur_q[23:16];
				res_g_q <= cur_q[15:8];
				res_b_q <= cur_q[7:0];
			end
			ST_MIX: begin
				ch_q <= ch_q + 1'b1;
				case (ch_q)
					2'd0:    res_r_q <= mix_res;
					2'd1:    res_g_q <= mix_res;
					default: res_b_q <= mix_res;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
			out_r_q <= res_r_q;
			out_g_q <= res_g_q;
			out_b_q <= res_b_q;
			out_bl_q <= res_bl_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_red     = out_r_q;
	assign out_green   = out_g_q;
	assign out_blue    = out_b_q;
	assign out_blanked = out_bl_q;

	// The divider is only started when it is free.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// A quotient arrives only while the sequencer waits for one.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_QWAIT || state_q == ST_FWAIT))
		else $error("divider finished outside a wait state");

	// The search never looks past the last segment in use.
	a_search_k: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCHA |-> k_q < nc)
		else $error("segment search out of range");

	// The point counter moves only when a word is delivered or a frame starts.
	a_cnt_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> ($past(state_q) == ST_DONE || $past(state_q) == ST_IDLE))
		else $error("point counter changed unexpectedly");

endmodule

FILE: test/pcpm_checker.sv
module pcpm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [2:0]         entry_index,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [15:0]        proportion,
	input  logic [15:0]        lit_count,
	input  logic [15:0]        phase,
	input  logic [15:0]        repeats,
	input  logic               blanked,
	input  logic [15:0]        pos_x,
	input  logic [15:0]        pos_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        out_x,
	input  logic [15:0]        out_y,
	input  logic [7:0]         out_red,
	input  logic [7:0]         out_green,
	input  logic [7:0]         out_blue,
	input  logic               out_blanked,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcpm_pkg::*;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        bl;
	} painted_point_t;

	painted_point_t painted_q[$];
	logic [23:0] colours[8];
	logic [15:0] weights[8];
	logic [15:0] frame_lit, frame_phase, frame_rep, counter;
	logic [3:0]  ncol_reg;
	logic        blend;

	function automatic logic [7:0] mix(logic [7:0] c, logic [7:0] n, logic [16:0] f);
		logic [63:0] v;
		v = 64'(c) * (64'd65536 - 64'(f)) + 64'(n) * 64'(f) + 64'd32768;
		return v[23:16];
	endfunction

	task automatic paint_point();
		painted_point_t p;
		int nc, k;
		logic [63:0] mag, q, total, target, run, f;
		logic [15:0] theta, rep;
		logic [23:0] cur, nxt;
		p = '{pos_x, pos_y, red, green, blue, blanked};
		nc = (ncol_reg > 8) ? 8 : ncol_reg;
		if (!blanked && nc != 0 && frame_lit != 0) begin
			rep = frame_rep[15] ? 16'(17'h10000 - frame_rep) : frame_rep;
			mag = 64'(counter) * 64'(rep) * 64'd256;
			if (frame_rep[15]) begin
				q = (mag + frame_lit - 1) / frame_lit;
				theta = frame_phase - q[15:0];
			end else begin
				q = mag / frame_lit;
				theta = q[15:0] + frame_phase;
			end
			total = 0;
			for (int i = 0; i < nc; i++) total += weights[i];
			target = 64'(theta) * total;
			run = 0;
			for (k = 0; k < nc; k++) begin
				if (((run + weights[k]) << 16) > target) break;
				run += weights[k];
			end
			if (k >= nc) begin
				p.r = 0; p.g = 0; p.b = 0;
			end else begin
				cur = colours[k];
				if (blend) begin
					nxt = colours[(k + 1) % nc];
					f = (target - (run << 16)) / weights[k];
					if (f > 65535) f = 65535;
					p.r = mix(cur[23:16], nxt[23:16], f[16:0]);
					p.g = mix(cur[15:8], nxt[15:8], f[16:0]);
					p.b = mix(cur[7:0], nxt[7:0], f[16:0]);
				end else begin
					{p.r, p.g, p.b} = cur;
				end
				counter++;
			end
		end
		painted_q.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		painted_point_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				colours[i] = 24'hFFFFFF;
				weights[i] = 16'd256;
			end
			frame_lit = 0; frame_phase = 0; frame_rep = 16'd256; counter = 0;
			ncol_reg = 1; blend = 0;
			painted_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_COLOUR_COUNT) ncol_reg = cfg_data;
				else blend = cfg_data[0];
			end
			if (in_valid && !in_stall) begin
				case (opcode)
				OP_LOAD_COLOUR: colours[entry_index] = {red, green, blue};
				OP_LOAD_WEIGHT: weights[entry_index] = (proportion == 0) ? 16'd1 : proportion;
				OP_FRAME: begin
					frame_lit = lit_count; frame_phase = phase;
					frame_rep = repeats; counter = 0;
				end
				default: paint_point();
				endcase
			end
			if (out_valid && !out_stall) begin
				if (painted_q.size() == 0) begin
					$error("unexpected word x=%0h y=%0h", out_x, out_y);
					fail_count++;
				end else begin
					e = painted_q.pop_front();
					if (out_x !== e.x) begin
						$error("out_x exp %0h got %0h", e.x, out_x); fail_count++;
					end
					if (out_y !== e.y) begin
						$error("out_y exp %0h got %0h", e.y, out_y); fail_count++;
					end
					if (out_red !== e.r) begin
						$error("out_red exp %0h got %0h", e.r, out_red); fail_count++;
					end
					if (out_green !== e.g) begin
						$error("out_green exp %0h got %0h", e.g, out_green); fail_count++;
					end
					if (out_blue !== e.b) begin
						$error("out_blue exp %0h got %0h", e.b, out_blue); fail_count++;
					end
					if (out_blanked !== e.bl) begin
						$error("out_blanked exp %0h got %0h", e.bl, out_blanked); fail_count++;
					end
				end
			end
		end
		pending = painted_q.size();
	end
endmodule

FILE: test/tb_proportional_colour_pattern_mapper.sv
module tb_proportional_colour_pattern_mapper;
	timeunit 1ns;
	timeprecision 1ps;
	import pcpm_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic cfg_valid = 0, cfg_ready, cfg_index = 0;
	logic [3:0] cfg_data = 0;
	logic [1:0] opcode = 0;
	logic [2:0] entry_index = 0;
	logic [7:0] red = 0, green = 0, blue = 0;
	logic [15:0] proportion = 0, lit_count = 0, phase = 0;
	logic signed [15:0] repeats = 0, pos_x = 0, pos_y = 0;
	logic blanked = 0;
	logic signed [15:0] out_x, out_y;
	logic [7:0] out_red, out_green, out_blue;
	logic out_blanked;
	int fail_count, pending;

	// Idling is switched off for one long stretch in the middle of the run.
	bit steady = 0;
	// While set, the receiver holds off entirely so the block backs up.
	bit hold_off = 0;

	always #1 clk = ~clk;

	proportional_colour_pattern_mapper i_dut (.*);

	pcpm_checker i_checker (.*);

	// The receiver stalls about a third of the time unless told otherwise.
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= !steady && ($urandom_range(99) < 34);
	end

	// Present one word and keep it steady until the block takes it. Random
	// idle cycles before the word put gaps at every point of the pipeline.
	// Valid stays high after the word is taken, so words can follow back to
	// back; an idle cycle or the caller drops it.
	task automatic send_word(logic [1:0] op, logic [2:0] idx, logic [23:0] rgb,
			logic [15:0] prop, logic [15:0] lit, logic [15:0] ph, logic [15:0] rep,
			logic bl, logic [15:0] x, logic [15:0] y);
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 0;
			@(posedge clk);
		end
		opcode <= op; entry_index <= idx; {red, green, blue} <= rgb;
		proportion <= prop; lit_count <= lit; phase <= ph; repeats <= rep;
		blanked <= bl; pos_x <= x; pos_y <= y;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_point(logic bl);
		send_word(OP_POINT, 3'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), bl, 16'($urandom), 16'($urandom));
	endtask

	// Wait until every expected word is back, then give a painted point in
	// flight time to finish before a register write.
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] data);
		cfg_index <= idx; cfg_data <= data; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// A random item, mostly points within a well-formed frame setup.
	task automatic random_word();
		int pick;
		logic [15:0] w;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_word(OP_LOAD_COLOUR, 3'($urandom), 24'($urandom), 0, 0, 0, 0, 0, 0, 0);
		end else if (pick < 16) begin
			w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
			if ($urandom_range(9) == 0) w = 0;
			send_word(OP_LOAD_WEIGHT, 3'($urandom), 0, w, 0, 0, 0, 0, 0, 0);
		end else if (pick < 22) begin
			send_word(OP_FRAME, 0, 0, 0,
				($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
				16'($urandom), 16'($urandom), 0, 0, 0);
		end else begin
			send_point($urandom_range(7) == 0);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset state, then table extremes and frame corner cases.
		send_point(0);
		send_point(1);
		send_word(OP_LOAD_COLOUR, 0, 24'h000000, 0, 0, 0, 0, 0, 0, 0);
		send_word(OP_LOAD_COLOUR, 7, 24'hFFFFFF, 0, 0, 0, 0, 0, 0, 0);
		send_word(OP_LOAD_COLOUR, 1, 24'hFF00FF, 0, 0, 0, 0, 0, 0, 0);
		send_word(OP_LOAD_WEIGHT, 0, 0, 16'd0, 0, 0, 0, 0, 0, 0);
		send_word(OP_LOAD_WEIGHT, 7, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(CFG_COLOUR_COUNT, 4'd15);
		write_reg(CFG_BLEND_ENABLE, 4'd1);
		send_word(OP_FRAME, 0, 0, 0, 16'd1, 16'hFFFF, 16'h7FFF, 0, 0, 0);
		send_point(0);
		send_point(0);
		send_word(OP_FRAME, 0, 0, 0, 16'hFFFF, 16'd0, 16'h8000, 0, 0, 0);
		send_word(OP_POINT, 0, 24'hFFFFFF, 0, 0, 0, 0, 0, 16'h7FFF, 16'h8000);
		send_word(OP_POINT, 0, 24'h000000, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF);
		send_word(OP_FRAME, 0, 0, 0, 16'd3, 16'd0, 16'hFF00, 0, 0, 0);
		repeat (4) send_point(0);
		send_word(OP_FRAME, 0, 0, 0, 16'd0, 16'd0, 16'd256, 0, 0, 0);
		send_point(0);
		drain();
		write_reg(CFG_COLOUR_COUNT, 4'd0);
		write_reg(CFG_BLEND_ENABLE, 4'd0);
		send_word(OP_FRAME, 0, 0, 0, 16'd5, 16'd0, 16'd256, 0, 0, 0);
		send_point(0);

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(CFG_COLOUR_COUNT, (ph == 0) ? 4'd8 : 4'($urandom_range(15)));
			write_reg(CFG_BLEND_ENABLE, 4'($urandom));
			steady = (ph == 2);
			for (int n = 0; n < 110; n++) random_word();
		end
		steady = 0;

		// Hold the receiver off while points keep coming, so the block backs up.
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int n = 0; n < 6; n++) send_point($urandom_range(1));
		join

		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
